FILE: sv/pdm_pkg.sv
`default_nettype none
package pdm_pkg;

	// field widths
	localparam int NODE_W     = 4;
	localparam int PROC_W     = 4;
	localparam int PRIO_W     = 3;
	localparam int TICKET_W   = 16;
	localparam int COUNT_W    = 5;
	localparam int GRANT_W    = 8;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	// sizing
	localparam int MAX_NODES     = 16;
	localparam int MAX_PROCS     = 16;
	localparam int PENDING_DEPTH = 32;
	localparam int RESULT_CAP    = 32;
	localparam int STORE_CAP     = (PENDING_DEPTH < RESULT_CAP) ? PENDING_DEPTH : RESULT_CAP;
	localparam int STORE_AW      = $clog2(STORE_CAP);
	localparam int STORE_CW      = $clog2(STORE_CAP + 1);
	localparam int ENTRY_W       = NODE_W + PROC_W;

	// input kinds
	localparam logic [KIND_W-1:0] KIND_REQ   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OK    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WANT  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LEAVE = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] OUT_OK    = 2'd0;
	localparam logic [KIND_W-1:0] OUT_BCAST = 2'd1;
	localparam logic [KIND_W-1:0] OUT_ENTER = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MY_NODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MY_PROCESS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MY_PRIO    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PROCS      = 3'd4;

	// result source select
	localparam logic [1:0] SRC_EXEC  = 2'd0;
	localparam logic [1:0] SRC_ENTER = 2'd1;
	localparam logic [1:0] SRC_WALK  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [NODE_W-1:0]   src_node;
		logic [PROC_W-1:0]   src_process;
		logic [TICKET_W-1:0] ticket;
		logic [PRIO_W-1:0]   priority_req;
		logic                origin_valid;
		logic [NODE_W-1:0]   origin_node;
		logic [PROC_W-1:0]   origin_process;
	} pdm_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]   out_kind;
		logic [NODE_W-1:0]   dest_node;
		logic [PROC_W-1:0]   dest_process;
		logic                carries_origin;
		logic [TICKET_W-1:0] out_ticket;
		logic [PRIO_W-1:0]   out_priority;
		logic                last;
	} pdm_result_t;

	typedef struct packed {
		logic       capture;
		logic       exec;
		logic       enter;
		logic       walk_start;
		logic       walk_step;
		logic       emit;
		logic [1:0] emit_src;
	} pdm_cmd_t;

	typedef struct packed {
		logic leave;
		logic exec_emits;
		logic enter_follow;
		logic store_empty;
		logic walk_last;
		logic slot_free;
	} pdm_status_t;

endpackage
`default_nettype wire

FILE: sv/pdm_in_if.sv
`default_nettype none
interface pdm_in_if
	import pdm_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [NODE_W-1:0]   src_node;
	logic [PROC_W-1:0]   src_process;
	logic [TICKET_W-1:0] ticket;
	logic [PRIO_W-1:0]   priority_req;
	logic                origin_valid;
	logic [NODE_W-1:0]   origin_node;
	logic [PROC_W-1:0]   origin_process;

	modport source (
		output valid, kind, src_node, src_process, ticket, priority_req,
			origin_valid, origin_node, origin_process,
		input ready
	);
	modport sink (
		input valid, kind, src_node, src_process, ticket, priority_req,
			origin_valid, origin_node, origin_process,
		output ready
	);
endinterface
`default_nettype wire

FILE: sv/pdm_out_if.sv
`default_nettype none
interface pdm_out_if
	import pdm_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   out_kind;
	logic [NODE_W-1:0]   dest_node;
	logic [PROC_W-1:0]   dest_process;
	logic                carries_origin;
	logic [TICKET_W-1:0] out_ticket;
	logic [PRIO_W-1:0]   out_priority;
	logic                last;

	modport source (
		output valid, out_kind, dest_node, dest_process, carries_origin,
			out_ticket, out_priority, last,
		input ready
	);
	modport sink (
		input valid, out_kind, dest_node, dest_process, carries_origin,
			out_ticket, out_priority, last,
		output ready
	);
endinterface
`default_nettype wire

FILE: sv/priority_distributed_mutex_node.sv
`default_nettype none
// One participant of a distributed mutual exclusion scheme with priority
// classes. Requests are ordered by class (larger wins), then ticket, node and
// process (smaller wins). Messages enter on in_ch, replies, broadcasts and the
// enter notice leave on out_ch, the final result of each item flagged by last.
// Items are handled one at a time: accept, execute, then the enter notice
// for a want that enters at once, or for a leave a walk of the deferred store
// through its single read port, one entry per cycle while the output register
// is free; a full output register not taken stalls the item. The user writes
// configuration via cfg_we/cfg_idx/cfg_wdata only while the node is idle; the
// block does not enforce it. The deferred store needs no clearing after reset.
module priority_distributed_mutex_node
	import pdm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	pdm_in_if.sink                     in_ch,
	pdm_out_if.source                  out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	pdm_item_t   item;
	pdm_result_t result;
	pdm_cmd_t    cmd;
	pdm_status_t status;
	logic        in_ready;
	logic        out_valid;

	// input payload gathering
	always_comb begin
		item.kind           = in_ch.kind;
		item.src_node       = in_ch.src_node;
		item.src_process    = in_ch.src_process;
		item.ticket         = in_ch.ticket;
		item.priority_req   = in_ch.priority_req;
		item.origin_valid   = in_ch.origin_valid;
		item.origin_node    = in_ch.origin_node;
		item.origin_process = in_ch.origin_process;
	end

	assign in_ch.ready = in_ready;

	pdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pdm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.result    (result)
	);

	// result payload
	assign out_ch.valid          = out_valid;
	assign out_ch.out_kind       = result.out_kind;
	assign out_ch.dest_node      = result.dest_node;
	assign out_ch.dest_process   = result.dest_process;
	assign out_ch.carries_origin = result.carries_origin;
	assign out_ch.out_ticket     = result.out_ticket;
	assign out_ch.out_priority   = result.out_priority;
	assign out_ch.last           = result.last;

endmodule
`default_nettype wire

FILE: sv/pdm_ctrl.sv
`default_nettype none
module pdm_ctrl
	import pdm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire pdm_status_t status,
	output pdm_cmd_t         cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_ENTER = 2'd2;
	localparam logic [1:0] S_WALK  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// sequencing of one item at a time
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!status.exec_emits || status.slot_free) begin
					cmd.exec     = 1'b1;
					cmd.emit     = status.exec_emits;
					cmd.emit_src = SRC_EXEC;
					if (status.leave && !status.store_empty) begin
						cmd.walk_start = 1'b1;
						state_d        = S_WALK;
					end else if (status.enter_follow) begin
						state_d = S_ENTER;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_ENTER: begin
				if (status.slot_free) begin
					cmd.enter    = 1'b1;
					cmd.emit     = 1'b1;
					cmd.emit_src = SRC_ENTER;
					state_d      = S_IDLE;
				end
			end
			S_WALK: begin
				if (status.slot_free) begin
					cmd.walk_step = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_src  = SRC_WALK;
					if (status.walk_last) begin
						state_d = S_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/pdm_datapath.sv
`default_nettype none
module pdm_datapath
	import pdm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire pdm_item_t             item,
	input  wire logic                  out_ready,
	input  wire pdm_cmd_t              cmd,
	output pdm_status_t                status,
	output logic                       out_valid,
	output pdm_result_t                result
);

	localparam int                 PROD_W    = 2 * COUNT_W;
	localparam int                 SUM_W     = PROD_W + 1;
	localparam logic [GRANT_W-1:0] GRANT_MAX = {GRANT_W{1'b1}};

	// configuration
	logic [NODE_W-1:0]  my_node_q;
	logic [PROC_W-1:0]  my_proc_q;
	logic [PRIO_W-1:0]  my_prio_q;
	logic [COUNT_W-1:0] node_count_q;
	logic [COUNT_W-1:0] procs_q;

	// protocol state
	pdm_item_t           item_q;
	logic [TICKET_W-1:0] hi_q;
	logic [TICKET_W-1:0] own_q;
	logic                wanting_q;
	logic                inside_q;
	logic [GRANT_W-1:0]  gs_q;
	logic [GRANT_W-1:0]  extra_q;
	logic [STORE_CW-1:0] cnt_q;
	logic [STORE_AW-1:0] idx_q;
	logic [ENTRY_W-1:0]  rd_q;
	logic [ENTRY_W-1:0]  store_q [STORE_CAP];

	// output register
	logic        out_valid_q;
	pdm_result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_node_q    <= '0;
			my_proc_q    <= '0;
			my_prio_q    <= '0;
			node_count_q <= COUNT_W'(1);
			procs_q      <= COUNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MY_NODE:    my_node_q    <= cfg_wdata[NODE_W-1:0];
				CFG_MY_PROCESS: my_proc_q    <= cfg_wdata[PROC_W-1:0];
				CFG_MY_PRIO:    my_prio_q    <= cfg_wdata[PRIO_W-1:0];
				CFG_NODE_COUNT: node_count_q <= cfg_wdata[COUNT_W-1:0];
				CFG_PROCS:      procs_q      <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// required grant count, clamped group size less one plus extra grants, clipped
	logic [COUNT_W-1:0] n_cl;
	logic [COUNT_W-1:0] p_cl;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   need_sum;
	logic [GRANT_W-1:0] req;

	always_comb begin
		if (node_count_q == '0) n_cl = COUNT_W'(1);
		else if (node_count_q > COUNT_W'(MAX_NODES)) n_cl = COUNT_W'(MAX_NODES);
		else n_cl = node_count_q;
		if (procs_q == '0) p_cl = COUNT_W'(1);
		else if (procs_q > COUNT_W'(MAX_PROCS)) p_cl = COUNT_W'(MAX_PROCS);
		else p_cl = procs_q;
		prod     = PROD_W'(n_cl) * PROD_W'(p_cl);
		need_sum = SUM_W'(prod) + SUM_W'(extra_q) - SUM_W'(1);
		req      = (need_sum > SUM_W'(GRANT_MAX)) ? GRANT_MAX : need_sum[GRANT_W-1:0];
	end

	// decision for the captured item
	logic                later;
	logic                do_defer;
	logic [ENTRY_W-1:0]  def_entry;
	logic                reply;
	logic                carry;
	logic                extra_up;
	logic                gs_up;
	logic                ok_enter;
	logic                bcast;
	logic                enter_now;
	logic [GRANT_W-1:0]  gs_inc;
	logic [TICKET_W-1:0] next_ticket;

	always_comb begin
		gs_inc      = (gs_q == GRANT_MAX) ? gs_q : gs_q + GRANT_W'(1);
		next_ticket = hi_q + TICKET_W'(1);
		enter_now   = gs_q >= req;
		later = (item_q.priority_req == my_prio_q) &&
			((own_q < item_q.ticket) ||
			 (own_q == item_q.ticket && my_node_q < item_q.src_node) ||
			 (own_q == item_q.ticket && my_node_q == item_q.src_node &&
			  my_proc_q < item_q.src_process));
		do_defer  = 1'b0;
		def_entry = {item_q.src_node, item_q.src_process};
		reply     = 1'b0;
		carry     = 1'b0;
		extra_up  = 1'b0;
		gs_up     = 1'b0;
		ok_enter  = 1'b0;
		bcast     = 1'b0;
		unique case (item_q.kind)
			KIND_REQ: begin
				priority if (inside_q) begin
					do_defer = 1'b1;
				end else if (item_q.priority_req > my_prio_q) begin
					reply    = 1'b1;
					carry    = wanting_q;
					extra_up = wanting_q;
				end else if (wanting_q && (item_q.priority_req < my_prio_q || later)) begin
					do_defer = 1'b1;
				end else begin
					reply = 1'b1;
				end
			end
			KIND_OK: begin
				do_defer  = item_q.origin_valid;
				def_entry = {item_q.origin_node, item_q.origin_process};
				if (wanting_q && !inside_q) begin
					gs_up    = 1'b1;
					ok_enter = gs_inc >= req;
				end
			end
			KIND_WANT: begin
				bcast = !wanting_q && !inside_q;
			end
			KIND_LEAVE: ;
		endcase
	end

	// status toward the controller
	logic slot_free;
	logic walk_last;

	assign slot_free = !out_valid_q || out_ready;
	assign walk_last = (STORE_CW'(idx_q) == cnt_q - STORE_CW'(1));

	always_comb begin
		status.leave        = item_q.kind == KIND_LEAVE;
		status.exec_emits   = reply || ok_enter || bcast;
		status.enter_follow = bcast && enter_now;
		status.store_empty  = cnt_q == '0;
		status.walk_last    = walk_last;
		status.slot_free    = slot_free;
	end

	// protocol state updates
	logic store_wr;

	assign store_wr = cmd.exec && do_defer && (cnt_q < STORE_CW'(STORE_CAP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q      <= '0;
			own_q     <= '0;
			wanting_q <= 1'b0;
			inside_q  <= 1'b0;
			gs_q      <= '0;
			extra_q   <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
		end else begin
			if (cmd.exec) begin
				unique case (item_q.kind)
					KIND_REQ: begin
						if (item_q.ticket > hi_q) hi_q <= item_q.ticket;
						if (extra_up && extra_q != GRANT_MAX) extra_q <= extra_q + GRANT_W'(1);
					end
					KIND_OK: begin
						if (ok_enter) begin
							gs_q     <= '0;
							extra_q  <= '0;
							inside_q <= 1'b1;
						end else if (gs_up) begin
							gs_q <= gs_inc;
						end
					end
					KIND_WANT: begin
						if (bcast) begin
							wanting_q <= 1'b1;
							own_q     <= next_ticket;
						end
					end
					KIND_LEAVE: begin
						wanting_q <= 1'b0;
						inside_q  <= 1'b0;
						gs_q      <= '0;
						extra_q   <= '0;
					end
				endcase
			end
			if (cmd.enter) begin
				gs_q     <= '0;
				extra_q  <= '0;
				inside_q <= 1'b1;
			end
			if (store_wr) begin
				cnt_q <= cnt_q + STORE_CW'(1);
			end
			if (cmd.walk_start) begin
				idx_q <= '0;
			end
			if (cmd.walk_step) begin
				if (walk_last) cnt_q <= '0;
				else idx_q <= idx_q + STORE_AW'(1);
			end
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
	end

	// deferred store, one write or one registered read per cycle
	logic                rd_en;
	logic [STORE_AW-1:0] rd_addr;

	assign rd_en   = cmd.walk_start || (cmd.walk_step && !walk_last);
	assign rd_addr = cmd.walk_start ? '0 : idx_q + STORE_AW'(1);

	always_ff @(posedge clk) begin
		if (store_wr) store_q[cnt_q[STORE_AW-1:0]] <= def_entry;
		if (rd_en) rd_q <= store_q[rd_addr];
	end

	// result selection
	pdm_result_t res_d;

	always_comb begin
		res_d = '0;
		unique case (cmd.emit_src)
			SRC_EXEC: begin
				if (bcast) begin
					res_d.out_kind     = OUT_BCAST;
					res_d.out_ticket   = next_ticket;
					res_d.out_priority = my_prio_q;
					res_d.last         = !enter_now;
				end else if (ok_enter) begin
					res_d.out_kind = OUT_ENTER;
					res_d.last     = 1'b1;
				end else begin
					res_d.out_kind       = OUT_OK;
					res_d.dest_node      = item_q.src_node;
					res_d.dest_process   = item_q.src_process;
					res_d.carries_origin = carry;
					res_d.last           = 1'b1;
				end
			end
			SRC_ENTER: begin
				res_d.out_kind = OUT_ENTER;
				res_d.last     = 1'b1;
			end
			SRC_WALK: begin
				res_d.out_kind     = OUT_OK;
				res_d.dest_node    = rd_q[ENTRY_W-1:PROC_W];
				res_d.dest_process = rd_q[PROC_W-1:0];
				res_d.last         = walk_last;
			end
			default: res_d = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) res_q <= res_d;
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule
`default_nettype wire

FILE: sv/pdm_checker.sv
`default_nettype none
module pdm_checker
	import pdm_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [KIND_W-1:0]   out_kind,
	input wire logic [NODE_W-1:0]   dest_node,
	input wire logic [PROC_W-1:0]   dest_process,
	input wire logic                carries_origin,
	input wire logic [TICKET_W-1:0] out_ticket,
	input wire logic [PRIO_W-1:0]   out_priority,
	input wire logic                last
);

	// one item in flight: a transfer in closes the input for the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous item in flight");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
			$stable(dest_node) && $stable(dest_process) && $stable(last) &&
			$stable(out_ticket))
		else $error("stalled result changed");

	// enter notice ends its run and names nobody
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == OUT_ENTER |-> last && dest_node == '0 &&
			dest_process == '0 && !carries_origin)
		else $error("malformed enter result");

	// only a broadcast carries ticket and class
	a_bcast_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != OUT_BCAST |-> out_ticket == '0 && out_priority == '0)
		else $error("ticket on a non-broadcast result");

endmodule

bind priority_distributed_mutex_node pdm_checker u_pdm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_kind       (out_ch.out_kind),
	.dest_node      (out_ch.dest_node),
	.dest_process   (out_ch.dest_process),
	.carries_origin (out_ch.carries_origin),
	.out_ticket     (out_ch.out_ticket),
	.out_priority   (out_ch.out_priority),
	.last           (out_ch.last)
);
`default_nettype wire

FILE: bench/priority_distributed_mutex_node_tb.sv
`timescale 1ns / 1ps

module priority_distributed_mutex_node_tb;
	import pdm_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	pdm_in_if  in_ch ();
	pdm_out_if out_ch ();

	priority_distributed_mutex_node u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the node: configuration
	logic [NODE_W-1:0]  reg_node = '0;
	logic [PROC_W-1:0]  reg_proc = '0;
	logic [PRIO_W-1:0]  reg_prio = '0;
	logic [COUNT_W-1:0] reg_ncount = 5'd1;
	logic [COUNT_W-1:0] reg_ppn = 5'd1;

	// shadow of the node: protocol state
	logic [TICKET_W-1:0] top_ticket = '0;
	logic [TICKET_W-1:0] held_ticket = '0;
	bit                  wanting_q = 1'b0;
	bit                  in_cs = 1'b0;
	int                  grant_cnt = 0;
	int                  bonus_cnt = 0;
	logic [ENTRY_W-1:0]  parked[$];

	pdm_result_t step_out[$];
	pdm_result_t outbound_due[$];
	int          mismatches = 0;

	// stimulus side
	pdm_item_t           pending_msgs[$];
	pdm_item_t           drv_item;
	logic [TICKET_W-1:0] gen_top = '0;
	logic [NODE_W-1:0]   plan_node = '0;
	logic [PROC_W-1:0]   plan_proc = '0;
	logic [PRIO_W-1:0]   plan_prio = '0;
	int                  plan_group = 1;
	int                  staged = 0;

	bit          in_taken = 1'b0;
	int unsigned cyc = 0;
	logic        calm;

	// a recurring long window with no idling on either side
	assign calm = (cyc % 3000) >= 2000;

	function automatic int grants_needed();
		int n, p, t;
		n = int'(reg_ncount);
		p = int'(reg_ppn);
		if (n < 1) n = 1;
		if (n > MAX_NODES) n = MAX_NODES;
		if (p < 1) p = 1;
		if (p > MAX_PROCS) p = MAX_PROCS;
		t = n * p - 1 + bonus_cnt;
		return (t > 255) ? 255 : t;
	endfunction

	function automatic pdm_result_t mk_result(input logic [KIND_W-1:0] k,
		input logic [NODE_W-1:0] dn, input logic [PROC_W-1:0] dp, input logic org,
		input logic [TICKET_W-1:0] tk, input logic [PRIO_W-1:0] pr);
		pdm_result_t r;
		r.out_kind       = k;
		r.dest_node      = dn;
		r.dest_process   = dp;
		r.carries_origin = org;
		r.out_ticket     = tk;
		r.out_priority   = pr;
		r.last           = 1'b0;
		return r;
	endfunction

	// store saturates: late arrivals are dropped
	task automatic park(input logic [NODE_W-1:0] n, input logic [PROC_W-1:0] p);
		if (parked.size() < STORE_CAP)
			parked.push_back({n, p});
	endtask

	task automatic grant_entry();
		grant_cnt = 0;
		bonus_cnt = 0;
		in_cs = 1'b1;
		step_out.push_back(mk_result(OUT_ENTER, '0, '0, 1'b0, '0, '0));
	endtask

	// expected output messages for one accepted input message
	task automatic node_respond(input pdm_item_t it);
		bit          later;
		pdm_result_t r;
		int          i;
		step_out.delete();
		case (it.kind)
			KIND_REQ: begin
				if (it.ticket > top_ticket)
					top_ticket = it.ticket;
				// same class: the peer loses on ticket, then node, then process
				later = it.priority_req == reg_prio &&
					(held_ticket < it.ticket ||
					(held_ticket == it.ticket && reg_node < it.src_node) ||
					(held_ticket == it.ticket && reg_node == it.src_node &&
					reg_proc < it.src_process));
				if (in_cs) begin
					park(it.src_node, it.src_process);
				end else if (it.priority_req > reg_prio) begin
					step_out.push_back(mk_result(OUT_OK, it.src_node, it.src_process,
						wanting_q, '0, '0));
					if (wanting_q && bonus_cnt < 255)
						bonus_cnt++;
				end else if (wanting_q && (it.priority_req < reg_prio || later)) begin
					park(it.src_node, it.src_process);
				end else begin
					step_out.push_back(mk_result(OUT_OK, it.src_node, it.src_process,
						1'b0, '0, '0));
				end
			end
			KIND_OK: begin
				if (it.origin_valid)
					park(it.origin_node, it.origin_process);
				if (wanting_q && !in_cs) begin
					if (grant_cnt < 255)
						grant_cnt++;
					if (grant_cnt >= grants_needed())
						grant_entry();
				end
			end
			KIND_WANT: begin
				if (!wanting_q && !in_cs) begin
					wanting_q = 1'b1;
					held_ticket = top_ticket + 16'd1;
					step_out.push_back(mk_result(OUT_BCAST, '0, '0, 1'b0, held_ticket,
						reg_prio));
					if (grant_cnt >= grants_needed())
						grant_entry();
				end
			end
			KIND_LEAVE: begin
				wanting_q = 1'b0;
				in_cs = 1'b0;
				grant_cnt = 0;
				bonus_cnt = 0;
				for (i = 0; i < parked.size(); i++)
					step_out.push_back(mk_result(OUT_OK, parked[i][ENTRY_W-1:PROC_W],
						parked[i][PROC_W-1:0], 1'b0, '0, '0));
				parked.delete();
			end
			default: ;
		endcase
		// flag the final message of this step
		for (i = 0; i < step_out.size(); i++) begin
			r = step_out[i];
			r.last = (i == step_out.size() - 1);
			outbound_due.push_back(r);
		end
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_MY_NODE:    reg_node = val[NODE_W-1:0];
			CFG_MY_PROCESS: reg_proc = val[PROC_W-1:0];
			CFG_MY_PRIO:    reg_prio = val[PRIO_W-1:0];
			CFG_NODE_COUNT: reg_ncount = val;
			CFG_PROCS:      reg_ppn = val;
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	function automatic pdm_item_t in_ch_item();
		pdm_item_t it;
		it.kind           = in_ch.kind;
		it.src_node       = in_ch.src_node;
		it.src_process    = in_ch.src_process;
		it.ticket         = in_ch.ticket;
		it.priority_req   = in_ch.priority_req;
		it.origin_valid   = in_ch.origin_valid;
		it.origin_node    = in_ch.origin_node;
		it.origin_process = in_ch.origin_process;
		return it;
	endfunction

	task automatic drain_one(input pdm_result_t e);
		check_field("out_kind", 32'(e.out_kind), 32'(out_ch.out_kind));
		check_field("dest_node", 32'(e.dest_node), 32'(out_ch.dest_node));
		check_field("dest_process", 32'(e.dest_process), 32'(out_ch.dest_process));
		check_field("carries_origin", 32'(e.carries_origin), 32'(out_ch.carries_origin));
		check_field("out_ticket", 32'(e.out_ticket), 32'(out_ch.out_ticket));
		check_field("out_priority", 32'(e.out_priority), 32'(out_ch.out_priority));
		check_field("last", 32'(e.last), 32'(out_ch.last));
	endtask

	// monitor: register writes, output transfers, input transfers
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n) begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (cfg_we)
				apply_reg(cfg_idx, cfg_wdata);
			if (out_ch.valid && out_ch.ready) begin
				if (outbound_due.size() == 0) begin
					$error("unexpected output transfer, out_kind %0d", out_ch.out_kind);
					mismatches++;
				end else begin
					drain_one(outbound_due.pop_front());
				end
			end
			if (in_ch.valid && in_ch.ready)
				node_respond(in_ch_item());
		end
	end

	// input driver: hold each message until its transfer, idle now and then
	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (pending_msgs.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
				drv_item = pending_msgs.pop_front();
				in_ch.valid          <= 1'b1;
				in_ch.kind           <= drv_item.kind;
				in_ch.src_node       <= drv_item.src_node;
				in_ch.src_process    <= drv_item.src_process;
				in_ch.ticket         <= drv_item.ticket;
				in_ch.priority_req   <= drv_item.priority_req;
				in_ch.origin_valid   <= drv_item.origin_valid;
				in_ch.origin_node    <= drv_item.origin_node;
				in_ch.origin_process <= drv_item.origin_process;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(negedge clk)
		out_ch.ready <= calm || $urandom_range(99) >= 6;

	function automatic pdm_item_t random_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(pdm_item_t)-1:0];
	endfunction

	task automatic stage(input pdm_item_t it);
		if (it.kind == KIND_REQ && it.ticket > gen_top)
			gen_top = it.ticket;
		pending_msgs.push_back(it);
		staged++;
	endtask

	task automatic stage_req(input logic [NODE_W-1:0] sn, input logic [PROC_W-1:0] sp,
		input logic [TICKET_W-1:0] tk, input logic [PRIO_W-1:0] pr);
		pdm_item_t it;
		it = random_item();
		it.kind         = KIND_REQ;
		it.src_node     = sn;
		it.src_process  = sp;
		it.ticket       = tk;
		it.priority_req = pr;
		stage(it);
	endtask

	task automatic stage_ok(input logic ov);
		pdm_item_t it;
		it = random_item();
		it.kind         = KIND_OK;
		it.origin_valid = ov;
		stage(it);
	endtask

	task automatic stage_cmd(input logic [KIND_W-1:0] k);
		pdm_item_t it;
		it = random_item();
		it.kind = k;
		stage(it);
	endtask

	// stray traffic; tickets kept near the running maximum unless wide
	function automatic pdm_item_t noise_item(input bit wide);
		pdm_item_t it;
		it = random_item();
		if (!wide)
			it.ticket = gen_top + 16'($urandom_range(8));
		return it;
	endfunction

	function automatic logic [TICKET_W-1:0] near_ticket(input logic [TICKET_W-1:0] mine);
		case ($urandom_range(3))
			0: return mine - 16'd1;
			1: return mine;
			2: return mine + 16'd1;
			default: return mine + 16'($urandom_range(40));
		endcase
	endfunction

	// peer request with class and identity close to ours, to hit the tie-breaks
	task automatic stage_peer(input logic [TICKET_W-1:0] mine, output logic [PRIO_W-1:0] pr);
		logic [NODE_W-1:0] sn;
		logic [PROC_W-1:0] sp;
		case ($urandom_range(3))
			0: pr = plan_prio;
			1: pr = plan_prio + 3'd1;
			2: pr = plan_prio - 3'd1;
			default: pr = 3'($urandom);
		endcase
		if ($urandom_range(2) == 0) begin
			sn = plan_node;
			sp = plan_proc + 4'($urandom_range(2)) - 4'd1;
		end else begin
			sn = 4'($urandom);
			sp = 4'($urandom);
		end
		stage_req(sn, sp, near_ticket(mine), pr);
	endtask

	// noise, want, grants mixed with peer requests, traffic while inside, usually a leave
	task automatic stage_round(input int grant_cap, input bit flood, input bit wide);
		int                  oks, sent, piled;
		logic [TICKET_W-1:0] mine;
		logic [PRIO_W-1:0]   pr;
		repeat ($urandom_range(2))
			stage(noise_item(wide));
		mine = gen_top + 16'd1;
		stage_cmd(KIND_WANT);
		oks = plan_group - 1;
		if (oks > grant_cap)
			oks = grant_cap;
		if (oks > 0 && $urandom_range(9) == 0)
			oks--;
		sent = 0;
		while (sent < oks) begin
			if ($urandom_range(2) == 0) begin
				stage_peer(mine, pr);
				// a higher class peer costs one more grant
				if (pr > plan_prio && oks < grant_cap)
					oks++;
			end
			stage_ok($urandom_range(3) == 0);
			sent++;
		end
		piled = flood ? STORE_CAP + 2 : $urandom_range(3);
		repeat (piled)
			stage_peer(mine, pr);
		if ($urandom_range(3) == 0)
			stage_ok(1'b1);
		if ($urandom_range(19) != 0)
			stage_cmd(KIND_LEAVE);
	endtask

	task automatic run_rounds(input int budget, input bit flood, input bit wide);
		staged = 0;
		stage_round(1000, flood, wide);
		while (staged < budget)
			stage_round(1000, 1'b0, wide);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
	endtask

	task automatic write_regs(input logic [NODE_W-1:0] nd, input logic [PROC_W-1:0] pc,
		input logic [PRIO_W-1:0] pr, input logic [COUNT_W-1:0] nc,
		input logic [COUNT_W-1:0] pp);
		int n, p;
		plan_node = nd;
		plan_proc = pc;
		plan_prio = pr;
		n = int'(nc);
		p = int'(pp);
		if (n < 1) n = 1;
		if (n > MAX_NODES) n = MAX_NODES;
		if (p < 1) p = 1;
		if (p > MAX_PROCS) p = MAX_PROCS;
		plan_group = n * p;
		put_reg(CFG_MY_NODE, {1'b0, nd});
		put_reg(CFG_MY_PROCESS, {1'b0, pc});
		put_reg(CFG_MY_PRIO, {2'b00, pr});
		put_reg(CFG_NODE_COUNT, nc);
		put_reg(CFG_PROCS, pp);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// nothing queued, nothing in transfer, nothing owed, then settle
	task automatic wait_idle();
		while (pending_msgs.size() != 0 || in_ch.valid || outbound_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		in_ch.valid          = 1'b0;
		in_ch.kind           = '0;
		in_ch.src_node       = '0;
		in_ch.src_process    = '0;
		in_ch.ticket         = '0;
		in_ch.priority_req   = '0;
		in_ch.origin_valid   = 1'b0;
		in_ch.origin_node    = '0;
		in_ch.origin_process = '0;
		out_ch.ready         = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// group of one at reset settings
		stage_req(4'd15, 4'd15, 16'd5, 3'd0);    // idle node answers at once
		stage_req(4'd0, 4'd0, 16'd0, 3'd7);      // higher class while idle: plain reply
		stage_ok(1'b1);                          // stray grant, origin still kept
		stage_ok(1'b0);                          // stray grant, ignored
		stage_cmd(KIND_WANT);                    // broadcast then immediate entry
		stage_cmd(KIND_WANT);                    // repeated want, ignored
		stage_req(4'd15, 4'd0, 16'd3, 3'd7);     // inside: deferred regardless of class
		stage_ok(1'b1);                          // inside: origin kept, not counted
		stage_cmd(KIND_LEAVE);                   // replies in arrival order
		stage_cmd(KIND_LEAVE);                   // empty store, nothing out
		wait_idle();

		// two members, class 3, own ticket 6
		write_regs(4'd7, 4'd8, 3'd3, 5'd2, 5'd1);
		stage_cmd(KIND_WANT);
		stage_req(4'd1, 4'd1, 16'd100, 3'd5);    // higher class: reply names us, extra grant
		stage_req(4'd2, 4'd2, 16'd1, 3'd1);      // lower class: deferred
		stage_req(4'd9, 4'd9, 16'd7, 3'd3);      // later ticket: deferred
		stage_req(4'd7, 4'd9, 16'd6, 3'd3);      // tie down to process, peer larger: deferred
		stage_req(4'd7, 4'd8, 16'd6, 3'd3);      // same identity: answered
		stage_req(4'd6, 4'd15, 16'd6, 3'd3);     // tie on ticket, smaller node: answered
		stage_req(4'd0, 4'd0, 16'd5, 3'd3);      // earlier ticket: answered
		stage_ok(1'b0);
		stage_ok(1'b1);                          // second grant enters
		stage_cmd(KIND_LEAVE);
		wait_idle();

		write_regs(4'd15, 4'd0, 3'd7, 5'd3, 5'd2);
		run_rounds(40, 1'b0, 1'b0);
		wait_idle();

		write_regs(4'd0, 4'd15, 3'd0, 5'd1, 5'd4);
		run_rounds(30, 1'b0, 1'b0);
		wait_idle();

		// out of range counts clamp; first round overflows the store
		write_regs(4'd5, 4'd5, 3'd4, 5'd31, 5'd0);
		run_rounds(40, 1'b1, 1'b0);
		wait_idle();

		// largest group: grant target clipped at 255, no early entry
		write_regs(4'd10, 4'd3, 3'd2, 5'd16, 5'd16);
		staged = 0;
		stage_round(40, 1'b0, 1'b0);
		wait_idle();

		write_regs(4'($urandom), 4'($urandom), 3'($urandom),
			5'($urandom_range(4, 1)), 5'($urandom_range(4, 1)));
		run_rounds(40, 1'b0, 1'b0);
		wait_idle();

		// ticket wraps to zero, then full range tickets
		write_regs(4'($urandom), 4'($urandom), 3'($urandom),
			5'($urandom_range(3, 1)), 5'($urandom_range(3, 1)));
		stage_req(4'($urandom), 4'($urandom), 16'hFFFF, 3'($urandom));
		run_rounds(50, 1'b1, 1'b1);
		wait_idle();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#(250_000 * 12);
		$display("Some tests failed");
		$finish;
	end

endmodule
